>>> rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list.
// No dependencies; imported by positional_array_list_top.
`default_nettype none

package pal_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = 7;
   localparam int DATA_W = 32;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_FIND   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BADPOS   = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [CNT_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] match_position;
      logic [CNT_W-1:0] count;
      logic             last;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/core/positional_array_list_top.sv
// Positional array list: insert, delete and find over a stored ordered list.
// Depends on pal_pkg for payload types, request codes and status codes.
// Full, bad-position, delete-at-end and empty-find answer straight from S_IDLE;
// an insert at the end writes directly; others shift up, deletes shift down, finds scan.
// One entry moved or compared per cycle; next request accepted once busy drops.
// Sync reset empties the list; entries hold no reset; results are never stalled.
`default_nettype none

module positional_array_list_top
   import pal_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output      logic            busy,
   input  wire req_payload_type req,
   output      logic            rsp_valid,
   output      rsp_payload_type rsp
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_INS_SHIFT = 9'b000000010,
      S_INS_FLUSH = 9'b000000100,
      S_INS_PUT   = 9'b000001000,
      S_DEL_SHIFT = 9'b000010000,
      S_DEL_FLUSH = 9'b000100000,
      S_FIND      = 9'b001000000,
      S_FIND_END  = 9'b010000000,
      S_FIND_LAST = 9'b100000000
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [1:0]               op_ff, op_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]         match_ff, match_in;
   logic                     have_ff, have_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic signed [DATA_W-1:0] mem_wdata;

   logic [CNT_W-1:0] pos_m1;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W:0]   cnt_p1;
   logic             hit;

   assign pos_m1 = pos_ff - CNT_W'(1);
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_p1 = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign hit    = rd_valid_ff && (op_ff == REQ_FIND) && (rd_data_ff == value_ff);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entries_ff[ptr_ff];
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = rd_idx_ff + IDX_W'(1);
      mem_wdata = rd_data_ff;
      priority if (state_ff == S_INS_PUT) begin
         mem_we    = 1'b1;
         mem_waddr = pos_m1[IDX_W-1:0];
         mem_wdata = value_ff;
      end else if (rd_valid_ff && (op_ff == REQ_INSERT)) begin
         mem_we = 1'b1;
      end else if (rd_valid_ff && (op_ff == REQ_DELETE)) begin
         mem_we    = 1'b1;
         mem_waddr = rd_idx_ff - IDX_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      match_in     = match_ff;
      have_in      = have_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (hit) begin
         if (have_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = ST_OK;
            rsp_in.match_position = match_ff;
            rsp_in.last           = 1'b0;
         end
         match_in = CNT_W'(rd_idx_ff) + CNT_W'(1);
         have_in  = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req.req_type;
               pos_in   = req.position;
               value_in = req.value;
               have_in  = 1'b0;
               unique case (req.req_type)
                  REQ_INSERT: begin
                     rsp_in.last = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else if ((req.position == '0) ||
                                  ({1'b0, req.position} > cnt_p1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_BADPOS;
                     end else if ({1'b0, req.position} == cnt_p1) begin
                        state_in = S_INS_PUT;
                     end else begin
                        ptr_in   = cnt_m1[IDX_W-1:0];
                        state_in = S_INS_SHIFT;
                     end
                  end
                  REQ_DELETE: begin
                     rsp_in.last = 1'b1;
                     if ((req.position == '0) || (req.position > count_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_BADPOS;
                     end else if (req.position == count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_OK;
                        count_in      = cnt_m1;
                     end else begin
                        ptr_in   = req.position[IDX_W-1:0];
                        state_in = S_DEL_SHIFT;
                     end
                  end
                  REQ_FIND: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_NOTFOUND;
                        rsp_in.last   = 1'b1;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_FIND;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_INS_SHIFT: begin
            rd_valid_in = 1'b1;
            if (ptr_ff == pos_m1[IDX_W-1:0]) begin
               state_in = S_INS_FLUSH;
            end else begin
               ptr_in = ptr_ff - IDX_W'(1);
            end
         end
         S_INS_FLUSH: begin
            state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            count_in      = count_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_in.status = ST_OK;
            rsp_in.last   = 1'b1;
            state_in      = S_IDLE;
         end
         S_DEL_SHIFT: begin
            rd_valid_in = 1'b1;
            if (ptr_ff == cnt_m1[IDX_W-1:0]) begin
               state_in = S_DEL_FLUSH;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         S_DEL_FLUSH: begin
            count_in      = cnt_m1;
            rsp_valid_in  = 1'b1;
            rsp_in.status = ST_OK;
            rsp_in.last   = 1'b1;
            state_in      = S_IDLE;
         end
         S_FIND: begin
            rd_valid_in = 1'b1;
            if (ptr_ff == cnt_m1[IDX_W-1:0]) begin
               state_in = S_FIND_END;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         S_FIND_END: begin
            state_in = S_FIND_LAST;
         end
         S_FIND_LAST: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (have_ff) begin
               rsp_in.status         = ST_OK;
               rsp_in.match_position = match_ff;
            end else begin
               rsp_in.status = ST_NOTFOUND;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      match_ff  <= match_in;
      rd_idx_ff <= ptr_ff;
      rsp_ff    <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CNT_W'(1)) ||
                        (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> busy)
      else $error("non-final result with no find in progress");

   a_full_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.req_type == REQ_INSERT) && (count_ff == CNT_W'(DEPTH)))
      |=> (rsp_valid && (rsp.status == ST_FULL) && rsp.last))
      else $error("insert on full list not refused");

   a_match_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.match_position != '0)) |-> (rsp.status == ST_OK))
      else $error("match position on a failing result");

endmodule

`default_nettype wire

>>> dv/positional_array_list_top_tb.sv
// Self-checking testbench for positional_array_list_top: directed and random insert,
// delete and find requests, each checked against a list tracker kept in the bench.
// Depends on pal_pkg and positional_array_list_top.
`timescale 1ns / 1ps

module positional_array_list_top_tb;
   import pal_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 80;

   class list_tracker;
      logic signed [DATA_W-1:0] shadow_entries [DEPTH];
      int                       shadow_count;
      rsp_payload_type          awaited_rsp [$];
      int                       errors;

      function new();
         shadow_count = 0;
         errors = 0;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type e;
         int pos;
         int hits;
         int k;
         pos = int'(r.position);
         e = '0;
         e.last = 1'b1;
         case (r.req_type)
            REQ_INSERT: begin
               if (shadow_count >= DEPTH) begin
                  e.status = ST_FULL;
               end else if (pos < 1 || pos > shadow_count + 1) begin
                  e.status = ST_BADPOS;
               end else begin
                  for (int j = shadow_count; j >= pos; j--)
                     shadow_entries[j] = shadow_entries[j-1];
                  shadow_entries[pos-1] = r.value;
                  shadow_count++;
                  e.status = ST_OK;
               end
               e.count = CNT_W'(shadow_count);
               awaited_rsp.push_back(e);
            end
            REQ_DELETE: begin
               if (pos < 1 || pos > shadow_count) begin
                  e.status = ST_BADPOS;
               end else begin
                  for (int j = pos; j < shadow_count; j++)
                     shadow_entries[j-1] = shadow_entries[j];
                  shadow_count--;
                  e.status = ST_OK;
               end
               e.count = CNT_W'(shadow_count);
               awaited_rsp.push_back(e);
            end
            REQ_FIND: begin
               hits = 0;
               for (int i = 0; i < shadow_count; i++)
                  if (shadow_entries[i] == r.value) hits++;
               e.count = CNT_W'(shadow_count);
               if (hits == 0) begin
                  e.status = ST_NOTFOUND;
                  awaited_rsp.push_back(e);
               end else begin
                  k = 0;
                  for (int i = 0; i < shadow_count; i++) begin
                     if (shadow_entries[i] == r.value) begin
                        k++;
                        e.status = ST_OK;
                        e.match_position = CNT_W'(i + 1);
                        e.last = (k == hits);
                        awaited_rsp.push_back(e);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(rsp_payload_type a);
         rsp_payload_type e;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, a);
            errors++;
            return;
         end
         e = awaited_rsp.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.match_position !== e.match_position) begin
            $display("%0t: match_position expected %0d actual %0d", $time,
                     e.match_position, a.match_position);
            errors++;
         end
         if (a.count !== e.count) begin
            $display("%0t: count expected %0d actual %0d", $time, e.count, a.count);
            errors++;
         end
         if (a.last !== e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req = '0;
   logic            rsp_valid;
   rsp_payload_type rsp;

   list_tracker tracker;
   int          cycle_count = 0;

   positional_array_list_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_response(rsp);
   end

   function automatic req_payload_type mk(logic [1:0] kind, logic [CNT_W-1:0] pos,
                                          logic signed [DATA_W-1:0] val);
      req_payload_type r;
      r.req_type = kind;
      r.position = pos;
      r.value = val;
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] pool_value();
      case ($urandom_range(0, 7))
         0: return 32'sh0;
         1: return -32'sd1;
         2: return 32'sh80000000;
         3: return 32'sh7fffffff;
         4: return 32'sd5;
         5: return 32'sd42;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type pick_request(bit growing);
      req_payload_type r;
      int roll;
      int n;
      n = tracker.shadow_count;
      roll = $urandom_range(0, 99);
      if (growing) roll = (roll < 80) ? 0 : (roll < 95) ? 60 : 95;
      if (roll < 30) begin
         r = mk(REQ_INSERT, CNT_W'($urandom_range(1, n + 1)), pool_value());
      end else if (roll < 60) begin
         r = mk(REQ_DELETE, CNT_W'($urandom_range(1, (n > 0) ? n : 1)), $urandom);
      end else if (roll < 85) begin
         if (n > 0 && $urandom_range(0, 1))
            r = mk(REQ_FIND, CNT_W'($urandom), tracker.shadow_entries[$urandom_range(0, n-1)]);
         else
            r = mk(REQ_FIND, CNT_W'($urandom), pool_value());
      end else begin
         r = mk(2'($urandom_range(0, 3)), CNT_W'($urandom_range(0, 127)), $urandom);
      end
      return r;
   endfunction

   task automatic issue_request(input req_payload_type r, input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req <= r;
      do @(posedge clock); while (busy);
      tracker.note_request(r);
   endtask

   initial begin
      int n;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_request(mk(REQ_FIND,   7'd0,   32'sh0), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd1,   32'sh0), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd0,   32'sh1), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd2,   32'sh1), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd1,   32'sh80000000), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd2,   32'sh7fffffff), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd1,   -32'sd1), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd3,   32'sh0), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd5,   -32'sd1), 1'b1);
      issue_request(mk(REQ_FIND,   7'd0,   -32'sd1), 1'b1);
      issue_request(mk(REQ_FIND,   7'd127, 32'sh7fffffff), 1'b1);
      issue_request(mk(REQ_FIND,   7'd0,   32'sh80000000), 1'b1);
      issue_request(mk(REQ_FIND,   7'd0,   32'sh1), 1'b1);
      issue_request(mk(2'd3,       7'd127, 32'sh5a5a5a5a), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd127, 32'sh0), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd6,   32'sh0), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd5,   32'sh0), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd1,   32'sh0), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd127, 32'sh1), 1'b1);

      n = 0;
      while (tracker.shadow_count < DEPTH) begin
         issue_request(pick_request(1'b1), !(n >= 30 && n < 70));
         n++;
      end
      issue_request(mk(REQ_INSERT, 7'd1,   32'sh1), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd0,   32'sh1), 1'b1);
      issue_request(mk(REQ_INSERT, 7'd127, 32'sh1), 1'b1);
      issue_request(mk(REQ_FIND,   7'd0,   -32'sd1), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd64,  32'sh0), 1'b1);
      issue_request(mk(REQ_DELETE, 7'd64,  32'sh0), 1'b1);

      repeat (40) issue_request(pick_request(1'b0), 1'b1);
      start <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pal_pkg.sv
rtl/core/positional_array_list_top.sv
dv/positional_array_list_top_tb.sv
